// ===== sv/gcvas_pkg.sv =====
// Shared types and constants for the greedy victim area selector.
// No dependencies; every other file of the block imports this package.
package gcvas_pkg;

  // Page summary states
  localparam logic [1:0] PageUsed = 2'd1;

  // Area kinds that can take part in a scan
  localparam logic [1:0] KindData  = 2'd0;
  localparam logic [1:0] KindIndex = 2'd1;

  // Scan result codes
  localparam logic [1:0] StatusFound = 2'd0;
  localparam logic [1:0] StatusNone  = 2'd1;
  localparam logic [1:0] StatusError = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgTargetKind   = 2'd0;
  localparam logic [1:0] CfgPagesPerArea = 2'd1;

  // Widths and reset values
  localparam int unsigned AreaW  = 10;
  localparam int unsigned TallyW = 7;
  localparam logic [TallyW-1:0] TallyMax       = 7'd127;
  localparam logic [TallyW-1:0] PagesPerAreaRst = 7'd64;

  // One page summary request
  typedef struct packed {
    logic [AreaW-1:0] area_number;
    logic             area_closed;
    logic [1:0]       area_kind;
    logic [1:0]       page_state;
    logic             summary_error;
    logic             last_page;
    logic             last_area;
  } in_item_t;

  // One scan result
  typedef struct packed {
    logic [AreaW-1:0] victim_area;
    logic             holds_data;
    logic [1:0]       scan_status;
  } out_item_t;

  // Classified page entry passed from front to back
  typedef struct packed {
    logic [AreaW-1:0] area;
    logic             eligible;
    logic             dirty;
    logic             err;
    logic             kind_match;
    logic             last_page;
    logic             last_area;
  } cls_rec_t;

endpackage

// ===== sv/gcvas_front.sv =====
// Front end: accepts page summary requests and classifies them.
// Depends on gcvas_pkg; feeds gcvas_queue.
module gcvas_front import gcvas_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     target_kind_i,
  input  logic     q_full_i,
  output logic     push_o,
  output cls_rec_t rec_o
);

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Classify the entry
  always_comb begin
    rec_o.area       = in_item_i.area_number;
    rec_o.eligible   = in_item_i.area_closed &
                       ((in_item_i.area_kind == KindData) ||
                        (in_item_i.area_kind == KindIndex));
    rec_o.dirty      = (in_item_i.page_state != PageUsed);
    rec_o.err        = in_item_i.summary_error;
    rec_o.kind_match = (in_item_i.area_kind == {1'b0, target_kind_i});
    rec_o.last_page  = in_item_i.last_page;
    rec_o.last_area  = in_item_i.last_area;
  end

endmodule

// ===== sv/gcvas_queue.sv =====
// Two-entry queue of classified entries between front and back.
// Depends on gcvas_pkg.
module gcvas_queue import gcvas_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cls_rec_t push_rec_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     not_empty_o,
  output cls_rec_t head_o
);

  localparam int unsigned Depth = 2;

  cls_rec_t   mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o      = (count_q == 2'(Depth));
  assign not_empty_o = (count_q != 2'd0);
  assign head_o      = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !not_empty_o))
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count did not advance on push");

endmodule

// ===== sv/gcvas_back.sv =====
// Back end: tallies dirty pages, tracks the best area and emits scan results.
// Depends on gcvas_pkg; drains gcvas_queue.
module gcvas_back import gcvas_pkg::*; #(
  parameter int unsigned MAX_PAGES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rec_valid_i,
  input  cls_rec_t          rec_i,
  output logic              pop_o,
  input  logic [TallyW-1:0] pages_per_area_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o
);

  localparam int unsigned ThrW =
    ($clog2(MAX_PAGES + 1) > TallyW) ? $clog2(MAX_PAGES + 1) : TallyW;

  logic [TallyW-1:0] tally_q, tally_d, tally_new;
  logic [AreaW-1:0]  best_area_q, best_area_d;
  logic [TallyW-1:0] best_dirty_q, best_dirty_d;
  logic              decided_q, decided_d;
  logic              data_flag_q, data_flag_d;
  logic              error_q, error_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;
  logic [ThrW-1:0]   thr;
  logic              active, full_area, scan_end, slot_free;

  // Clamp the fully dirty threshold
  assign thr = (ThrW'(pages_per_area_i) > ThrW'(MAX_PAGES)) ?
               ThrW'(MAX_PAGES) : ThrW'(pages_per_area_i);

  // Hold an ending entry until the output slot can take its result
  assign scan_end  = rec_i.last_page & rec_i.last_area;
  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign pop_o     = rec_valid_i & (~scan_end | slot_free);

  assign active    = rec_i.eligible & ~decided_q;
  assign tally_new = (active && !rec_i.err && rec_i.dirty && tally_q != TallyMax) ?
                     tally_q + 7'd1 : tally_q;
  assign full_area = (thr != '0) && (ThrW'(tally_new) == thr);

  // Update scan state
  always_comb begin
    tally_d      = tally_q;
    best_area_d  = best_area_q;
    best_dirty_d = best_dirty_q;
    decided_d    = decided_q;
    data_flag_d  = data_flag_q;
    error_d      = error_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_item_d   = out_item_q;
    if (pop_o) begin
      tally_d = rec_i.last_page ? '0 : tally_new;
      if (active && rec_i.err) begin
        error_d   = 1'b1;
        decided_d = 1'b1;
      end else if (active && rec_i.last_page) begin
        if (full_area) begin
          best_area_d = rec_i.area;
          data_flag_d = 1'b0;
          decided_d   = 1'b1;
        end else if (rec_i.kind_match && tally_new > best_dirty_q) begin
          best_area_d  = rec_i.area;
          best_dirty_d = tally_new;
        end
      end
      // Emit the result and clear the scan
      if (scan_end) begin
        out_valid_d = 1'b1;
        priority if (error_d) begin
          out_item_d = '{victim_area: '0, holds_data: 1'b1, scan_status: StatusError};
        end else if (best_area_d == '0) begin
          out_item_d = '{victim_area: '0, holds_data: 1'b1, scan_status: StatusNone};
        end else begin
          out_item_d = '{victim_area: best_area_d, holds_data: data_flag_d,
                         scan_status: StatusFound};
        end
        best_area_d  = '0;
        best_dirty_d = '0;
        decided_d    = 1'b0;
        data_flag_d  = 1'b1;
        error_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q      <= '0;
      best_area_q  <= '0;
      best_dirty_q <= '0;
      decided_q    <= 1'b0;
      data_flag_q  <= 1'b1;
      error_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      tally_q      <= tally_d;
      best_area_q  <= best_area_d;
      best_dirty_q <= best_dirty_d;
      decided_q    <= decided_d;
      data_flag_q  <= data_flag_d;
      error_q      <= error_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && scan_end) |=> (out_valid_q && !decided_q && tally_q == '0))
    else $error("scan end did not produce a result and clear state");
  a_flag_implies_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!data_flag_q || error_q) |-> decided_q)
    else $error("decision flag without decided");
  a_error_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.scan_status != StatusFound) |->
      (out_item_q.victim_area == '0 && out_item_q.holds_data))
    else $error("victim reported without a found status");

endmodule

// ===== sv/gc_victim_area_selector.sv =====
// Top level of the greedy victim area selector: config registers and wiring.
// Depends on gcvas_pkg, gcvas_front, gcvas_queue and gcvas_back.
//
//  channel | direction | handshake         | payload
//  in      | request   | in_valid/in_stall | in_item_t page summary entry
//  out     | result    | out_valid/out_stall | out_item_t scan result
//  cfg     | write     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One page entry is accepted each cycle while the queue has room; the
// two-entry queue and the back-end tally step set that rate. A result is
// offered from the back end's output register when the scan end pops.
// Reset restores target_kind 0 and pages_per_area 64 and empties the queue.
// A stalled result holds; entries keep flowing until a second scan end
// waits in the queue, and in_stall rises once the queue is full.
module gc_victim_area_selector import gcvas_pkg::*; #(
  parameter int unsigned MAX_PAGES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [TallyW-1:0] cfg_data_i
);

  logic              target_kind_q;
  logic [TallyW-1:0] pages_per_area_q;
  logic              push, pop, q_full, q_not_empty;
  cls_rec_t          push_rec, head_rec;

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_kind_q    <= 1'b0;
      pages_per_area_q <= PagesPerAreaRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTargetKind:   target_kind_q    <= cfg_data_i[0];
        CfgPagesPerArea: pages_per_area_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gcvas_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .target_kind_i(target_kind_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  gcvas_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_rec_i  (push_rec),
    .pop_i       (pop),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .head_o      (head_rec)
  );

  gcvas_back #(
    .MAX_PAGES(MAX_PAGES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_valid_i     (q_not_empty),
    .rec_i           (head_rec),
    .pop_o           (pop),
    .pages_per_area_i(pages_per_area_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_item_o      (out_item_o)
  );

endmodule
